// ===== src/mnht_pkg.sv =====
// Package for the name hash table: constants, request and result types,
// status codes and the fixed crypt table built from the seed recurrence.
// No dependencies.
`default_nettype none

package mnht_pkg;

  localparam int ENTRIES     = 1024;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = 11;
  localparam int CRYPT_WORDS = 768;

  localparam logic [31:0] SEED_A = 32'h7FED7FED;
  localparam logic [31:0] SEED_B = 32'hEEEEEEEE;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_FOUND     = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_DUPLICATE = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  typedef struct packed {
    logic       command;
    logic [7:0] name_char;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [9:0]  home_index;
    logic [31:0] check_word_a;
    logic [31:0] check_word_b;
  } out_res_t;

  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] ch;
  } hash_req_t;

  typedef struct packed {
    logic [31:0] h0;
    logic [31:0] wa;
    logic [31:0] wb;
  } hash_res_t;

  typedef struct packed {
    logic             blank;
    logic [IDX_W-1:0] home;
    logic [31:0]      wa;
    logic [31:0]      wb;
  } slot_t;

  typedef logic [31:0] crypt_t [CRYPT_WORDS];

  function automatic crypt_t build_crypt();
    crypt_t      tbl;
    logic [31:0] seed;
    logic [31:0] hi;
    logic [31:0] lo;
    seed = 32'h00100001;
    for (int col = 0; col < 256; col++) begin
      for (int row = 0; row < 5; row++) begin
        seed = (seed * 32'd125 + 32'd3) % 32'h2AAAAB;
        hi   = {seed[15:0], 16'h0000};
        seed = (seed * 32'd125 + 32'd3) % 32'h2AAAAB;
        lo   = {16'h0000, seed[15:0]};
        if (row < 3) begin
          tbl[row * 256 + col] = hi | lo;
        end
      end
    end
    return tbl;
  endfunction

  localparam crypt_t CRYPT = build_crypt();

endpackage

`default_nettype wire

// ===== src/mnht_hash.sv =====
// Three hash chains over the crypt table, one character per step.
// Depends on mnht_pkg for the crypt table, seeds and request types.
`default_nettype none

module mnht_hash
  import mnht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hash_req_t req,
  output hash_res_t      res
);

  logic [7:0]  ch_up;
  logic [31:0] s1_r  [3];
  logic [31:0] s2_r  [3];
  logic [31:0] s1_nxt[3];
  logic [31:0] s2_nxt[3];

  always_comb begin
    ch_up = req.ch;
    if (req.ch >= 8'h61 && req.ch <= 8'h7A) begin
      ch_up = req.ch - 8'h20;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_chain
    always_comb begin
      s1_nxt[k] = CRYPT[{2'(k), ch_up}] ^ (s1_r[k] + s2_r[k]);
      s2_nxt[k] = {24'h000000, ch_up} + s1_nxt[k] + s2_r[k] + {s2_r[k][26:0], 5'b00000}
                  + 32'd3;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_r[k] <= SEED_A;
        s2_r[k] <= SEED_B;
      end else if (req.step) begin
        if (req.last) begin
          s1_r[k] <= SEED_A;
          s2_r[k] <= SEED_B;
        end else begin
          s1_r[k] <= s1_nxt[k];
          s2_r[k] <= s2_nxt[k];
        end
      end
    end
  end

  assign res.h0 = s1_nxt[0];
  assign res.wa = s1_nxt[1];
  assign res.wb = s1_nxt[2];

endmodule

`default_nettype wire

// ===== src/mpq_name_hash_table.sv =====
// Top level of the name hash table: APB register, slot memory and probe control.
// Depends on mnht_pkg and mnht_hash.
`default_nettype none

// Names arrive one character per request while busy is low. After the last
// character busy stays high through a setup state and then a probe state that
// examines the slots in turn, from the home slot onward, since the single slot
// memory read port is visited once per cycle. The result is shown with out_valid
// for exactly one cycle, the first cycle in which busy is low, and must be taken
// then. After reset a clearing pass blanks the 1024 slots, one per cycle, with
// busy high; register writes are taken during it.
module mpq_name_hash_table
  import mnht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_req_t     in_req,
  output logic             out_valid,
  output out_res_t         out_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] home_r, home_nxt;
  logic [31:0]      wa_r, wa_nxt;
  logic [31:0]      wb_r, wb_nxt;
  logic             cmd_r, cmd_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_res_r, out_res_nxt;

  slot_t            mem [ENTRIES];
  slot_t            rd_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wdata;
  logic [IDX_W-1:0] raddr;

  hash_req_t        hreq;
  hash_res_t        hres;
  logic             accept;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] mask;
  logic [CNT_W-1:0] pos_inc_w;
  logic [IDX_W-1:0] pos_inc;
  logic             hit;
  logic             wrap;
  logic             cfg_wr;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'h0 : {21'h0, count_r};
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign hreq.step = accept;
  assign hreq.last = in_req.last_char;
  assign hreq.ch   = in_req.name_char;

  mnht_hash u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (hreq),
    .res  (hres)
  );

  always_comb begin
    cnt_eff = count_r;
    if (count_r < CNT_W'(2)) begin
      cnt_eff = CNT_W'(2);
    end else if (count_r > CNT_W'(ENTRIES)) begin
      cnt_eff = CNT_W'(ENTRIES);
    end
    cnt_m1    = cnt_eff - CNT_W'(1);
    mask      = cnt_m1[IDX_W-1:0];
    pos_inc_w = {1'b0, pos_r} + CNT_W'(1);
    pos_inc   = (pos_inc_w == cnt_eff) ? '0 : pos_inc_w[IDX_W-1:0];
    wrap      = (pos_inc == home_r);
    hit       = !rd_q.blank && (rd_q.home == home_r) && (rd_q.wa == wa_r)
                && (rd_q.wb == wb_r);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_wr ? pwdata[CNT_W-1:0] : count_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    home_nxt      = home_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata.blank   = 1'b0;
    wdata.home    = home_r;
    wdata.wa      = wa_r;
    wdata.wb      = wb_r;
    raddr         = home_r;

    out_res_nxt.home_index   = home_r;
    out_res_nxt.check_word_a = wa_r;
    out_res_nxt.check_word_b = wb_r;

    unique case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_r;
        wdata.blank = 1'b1;
        wdata.home  = '0;
        wdata.wa    = '0;
        wdata.wb    = '0;
        clr_nxt     = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_req.last_char) begin
          home_nxt  = hres.h0[IDX_W-1:0] & mask;
          wa_nxt    = hres.wa;
          wb_nxt    = hres.wb;
          cmd_nxt   = in_req.command;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        raddr     = home_r;
        pos_nxt   = home_r;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        raddr   = pos_inc;
        pos_nxt = pos_inc;
        if (cmd_r == CMD_LOOKUP) begin
          if (hit) begin
            out_res_nxt.status = STAT_FOUND;
            out_res_nxt.slot   = pos_r;
            out_valid_nxt      = 1'b1;
            state_nxt          = ST_IDLE;
          end else if (wrap) begin
            out_res_nxt.status = STAT_NOT_FOUND;
            out_res_nxt.slot   = '0;
            out_valid_nxt      = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end else begin
          if (rd_q.blank) begin
            we                 = 1'b1;
            out_res_nxt.status = STAT_INSERTED;
            out_res_nxt.slot   = pos_r;
            out_valid_nxt      = 1'b1;
            state_nxt          = ST_IDLE;
          end else if (hit) begin
            out_res_nxt.status = STAT_DUPLICATE;
            out_res_nxt.slot   = pos_r;
            out_valid_nxt      = 1'b1;
            state_nxt          = ST_IDLE;
          end else if (wrap) begin
            out_res_nxt.status = STAT_FULL;
            out_res_nxt.slot   = '0;
            out_valid_nxt      = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      count_r     <= CNT_W'(ENTRIES);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    home_r    <= home_nxt;
    wa_r      <= wa_nxt;
    wb_r      <= wb_nxt;
    cmd_r     <= cmd_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

`default_nettype wire

// ===== src/mnht_checker.sv =====
// Port-level checks on the name hash table, bound to the top level.
// Depends on mnht_pkg and mpq_name_hash_table.
`default_nettype none

module mnht_checker
  import mnht_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire in_req_t  in_req,
  input wire logic     out_valid,
  input wire out_res_t out_res
);

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_result_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result without a finished probe");

  a_no_result_mid_name: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req.last_char) |=> !out_valid)
    else $error("result after a character that is not the last");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.status == STAT_INSERTED || out_res.status == STAT_FOUND ||
                   out_res.status == STAT_NOT_FOUND || out_res.status == STAT_DUPLICATE ||
                   out_res.status == STAT_FULL))
    else $error("status code out of range");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == STAT_NOT_FOUND || out_res.status == STAT_FULL))
    |-> (out_res.slot == '0))
    else $error("slot not zero when no slot was taken");

endmodule

bind mpq_name_hash_table mnht_checker u_mnht_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_req   (in_req),
  .out_valid(out_valid),
  .out_res  (out_res)
);

`default_nettype wire
